// ===== src/strict_priority_fifo_server_macros.svh =====
// assertion macros used by the strict priority fifo server back end
`ifndef STRICT_PRIORITY_FIFO_SERVER_MACROS_SVH
`define STRICT_PRIORITY_FIFO_SERVER_MACROS_SVH

// same-cycle implication, checked on clk_i outside reset
`define SPFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i outside reset
`define SPFS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/spfs_pkg.sv =====
// types and constants of the strict priority fifo server
`timescale 1ns / 1ps

package spfs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned LEVELS_DEF      = 4;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned LEVEL_W = 2;

  // op field codes
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic               op;
    logic [ID_W-1:0]    customer_id;
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  service_time;
  } in_item_t;

  typedef struct packed {
    logic               answered;
    logic [ID_W-1:0]    served_id;
    logic [LEVEL_W-1:0] served_level;
    logic               dropped;
    logic               all_idle;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic               tick;
    logic [LEVEL_W-1:0] level;
    logic [ID_W-1:0]    customer_id;
    logic [TIME_W-1:0]  service_time;
  } cmd_t;

endpackage

// ===== src/spfs_ram.sv =====
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps

module spfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/spfs_front.sv =====
// front end: accepts items, classifies them and buffers commands for the back end
`timescale 1ns / 1ps

module spfs_front import spfs_pkg::*; #(
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_pop_i,
  output cmd_t     cmd_o
);

  localparam logic [1:0] FILL_FULL = 2'd2;

  cmd_t       cmd_in;
  cmd_t       buf_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;
  logic       push;
  logic       pop;

  // classify: tick or arrival, clamp level to the top existing queue
  always_comb begin
    cmd_in.tick         = (in_item_i.op == OP_TICK);
    cmd_in.level        = in_item_i.level;
    cmd_in.customer_id  = in_item_i.customer_id;
    cmd_in.service_time = in_item_i.service_time;
    if (32'(in_item_i.level) >= LEVELS) begin
      cmd_in.level = LEVEL_W'(LEVELS - 1);
    end
  end

  assign in_stall_o  = (fill_q == FILL_FULL);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = buf_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== src/spfs_back.sv =====
// back end: per-level fifo pointers, server countdown and result register
`timescale 1ns / 1ps
`include "strict_priority_fifo_server_macros.svh"

module spfs_back import spfs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned LEVELS      = LEVELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned LW        = $clog2(LEVELS);
  localparam int unsigned PW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW        = PW + 1;
  localparam int unsigned AW        = LW + PW;
  localparam int unsigned RAM_DEPTH = 2 ** AW;
  localparam int unsigned DW        = ID_W + TIME_W;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e            state_q;
  logic [PW-1:0]     heads_q [LEVELS];
  logic [CW-1:0]     counts_q [LEVELS];
  logic [TIME_W-1:0] rem_q;
  logic [LW-1:0]     pop_lvl_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              any_busy;
  logic [LW-1:0]     sel_lvl;
  logic [LW-1:0]     idx;
  logic [PW-1:0]     head_sel;
  logic [CW-1:0]     count_sel;
  logic              full;
  logic [SW-1:0]     slot_sum;
  logic [PW-1:0]     slot;
  logic [PW-1:0]     head_inc;
  logic [TIME_W-1:0] rem_dec;
  logic [TIME_W-1:0] time_dec;
  logic              out_free;
  logic              take;
  logic              is_pop;
  logic              wr_en;
  logic              rd_en;
  logic [DW-1:0]     rd_data;
  logic [ID_W-1:0]   rd_id;
  logic [TIME_W-1:0] rd_time;

  // highest non-empty level wins
  always_comb begin
    any_busy = 1'b0;
    sel_lvl  = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (counts_q[i] != '0) begin
        any_busy = 1'b1;
        sel_lvl  = LW'(i);
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = (state_q == S_IDLE) && cmd_valid_i && out_free;
  assign is_pop   = cmd_i.tick && (rem_q == '0) && any_busy;
  assign idx      = cmd_i.tick ? sel_lvl : LW'(cmd_i.level);

  assign head_sel  = heads_q[idx];
  assign count_sel = counts_q[idx];
  assign full      = (count_sel == CW'(QUEUE_DEPTH));

  // tail slot = head + count, wrapped once
  assign slot_sum = SW'(head_sel) + SW'(count_sel);
  assign slot     = (slot_sum >= SW'(QUEUE_DEPTH)) ? PW'(slot_sum - SW'(QUEUE_DEPTH))
                                                  : PW'(slot_sum);
  assign head_inc = (head_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + PW'(1);

  assign rd_id    = rd_data[DW-1:TIME_W];
  assign rd_time  = rd_data[TIME_W-1:0];
  assign rem_dec  = (rem_q == '0) ? '0 : rem_q - TIME_W'(1);
  assign time_dec = (rd_time == '0) ? '0 : rd_time - TIME_W'(1);

  assign wr_en = take && !cmd_i.tick && !full;
  assign rd_en = take && is_pop;

  spfs_ram #(
    .WIDTH (DW),
    .DEPTH (RAM_DEPTH)
  ) u_queue_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i ({idx, slot}),
    .wr_data_i ({cmd_i.customer_id, cmd_i.service_time}),
    .rd_en_i   (rd_en),
    .rd_addr_i ({idx, head_sel}),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rem_q       <= '0;
      pop_lvl_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        heads_q[i]  <= '0;
        counts_q[i] <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (take) begin
            if (!cmd_i.tick) begin
              if (!full) begin
                counts_q[idx] <= count_sel + CW'(1);
              end
              // the target queue holds an entry either way, so never idle
              out_valid_q <= 1'b1;
              out_q       <= '{answered: 1'b0, served_id: '0, served_level: '0,
                               dropped: full, all_idle: 1'b0};
            end else if (is_pop) begin
              heads_q[idx]  <= head_inc;
              counts_q[idx] <= count_sel - CW'(1);
              pop_lvl_q     <= idx;
              state_q       <= S_READ;
            end else begin
              rem_q       <= rem_dec;
              out_valid_q <= 1'b1;
              out_q       <= '{answered: 1'b0, served_id: '0, served_level: '0,
                               dropped: 1'b0, all_idle: (rem_dec == '0) && !any_busy};
            end
          end
        end
        S_READ: begin
          rem_q       <= time_dec;
          out_valid_q <= 1'b1;
          out_q       <= '{answered: 1'b1, served_id: rd_id,
                           served_level: LEVEL_W'(pop_lvl_q), dropped: 1'b0,
                           all_idle: (time_dec == '0) && !any_busy};
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_pop_o   = take;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SPFS_ASSERT_IMP(a_read_out_free, state_q == S_READ, !out_valid_q, "result register busy during queue read")
  `SPFS_ASSERT_NXT(a_pop_enters_read, take && is_pop, state_q == S_READ, "pop did not start a queue read")
  `SPFS_ASSERT_IMP(a_answer_not_drop, out_valid_q && out_q.answered, !out_q.dropped, "answered and dropped together")

  for (genvar g = 0; g < LEVELS; g++) begin : g_cnt_chk
    `SPFS_ASSERT_IMP(a_count_bound, 1'b1, 32'(counts_q[g]) <= QUEUE_DEPTH, "queue fill count above depth")
  end

endmodule

// ===== src/strict_priority_fifo_server.sv =====
// top level of the strict priority fifo server: front end, command queue and back end
// result path: arrivals and ticks that answer nobody pass the command queue, then the back
//   end registers the result; an answering tick reads the queue ram and then goes to S_READ
// throughput: 1 item per cycle unless a stalled result or S_READ holds the back end
// the 2-entry command queue lets up to two inputs arrive while a result waits on out_stall_i
// reset: rst_ni clears pointers, fill counts and the countdown; queue ram contents are
//   not cleared, entries are only read after they were pushed
`timescale 1ns / 1ps

module strict_priority_fifo_server import spfs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned LEVELS      = LEVELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // front to back command channel
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front: classify op, clamp level to an existing queue, buffer two commands
  spfs_front #(
    .LEVELS (LEVELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // back: pushes arrivals into per-level fifos in ram, serves the highest
  // non-empty level on a tick when the countdown is zero, holds the result item
  spfs_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LEVELS      (LEVELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
